>>> hdl/ftp_command_line_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// FTP command line tokenizer: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef FTP_COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define FTP_COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTP_TOK_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ftp_tok: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define FTP_TOK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ftp_tok: property violated");

`endif

>>> hdl/ftp_tok_pkg.sv
// ----------------------------------------------------------------------------
// FTP tokenizer package
// Result kinds, character codes and the control/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftp_tok_pkg;

  localparam int unsigned CMD_MAX   = 4;   // longest command word
  localparam int unsigned PLEN_W    = 6;   // param_len field width
  localparam int unsigned CLEN_W    = 3;   // cmd_len field width
  localparam int unsigned TEXT_W    = 32;  // cmd_text field width
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned TDATA_O_W = 56;  // 49 payload bits padded to bytes

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_PENDING  = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_CMD      = 3'd2,
    KIND_TOO_LONG = 3'd3,
    KIND_BAD_WORD = 3'd4,
    KIND_PARAM    = 3'd5
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic  store;        // append byte to line buffer
    logic  clear;        // drop the line
    logic  load;         // load output register
    kind_e kind;         // kind for the loaded result
    logic  start_param;  // latch parameter pointer and count
    logic  advance;      // step to next parameter byte
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic full;
    logic line_empty;
    logic word_bad;
    logic plen_zero;
    logic param_last;
  } dp_sts_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

>>> hdl/ftp_tok_dp.sv
// ----------------------------------------------------------------------------
// FTP tokenizer datapath
// Line buffer, running line scan, parameter pointer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftp_tok_dp #(
  parameter int unsigned LineCapacity = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [7:0]                         rx_byte_i,
  input  ftp_tok_pkg::ctrl_cmd_t             cmd_i,
  output ftp_tok_pkg::dp_sts_t               sts_o,
  output logic [ftp_tok_pkg::KIND_W-1:0]     kind_o,
  output logic [ftp_tok_pkg::TDATA_O_W-1:0]  data_o,
  output logic                               last_o
);

  localparam int unsigned AW = $clog2(LineCapacity);
  localparam int unsigned CW = $clog2(LineCapacity + 1);
  localparam int unsigned NB = ftp_tok_pkg::CMD_MAX;

  logic [7:0] mem_q [LineCapacity];
  logic [7:0] rd_q;

  logic [CW-1:0] fill_q, fill_d;
  logic          zero_seen_q, zero_seen_d;
  logic [AW-1:0] zero_pos_q, zero_pos_d;
  logic          sp_found_q, sp_found_d;
  logic [AW-1:0] sp_pos_q, sp_pos_d;
  logic          ps_found_q, ps_found_d;
  logic [AW-1:0] ps_pos_q, ps_pos_d;
  logic [7:0]    word_q [NB];

  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] rem_q, rem_d;

  logic [7:0] ch;
  logic [CW-1:0] len, word, pstart, plen;
  logic [ftp_tok_pkg::TEXT_W-1:0] text;

  ftp_tok_pkg::kind_e                kind_q;
  logic [ftp_tok_pkg::TEXT_W-1:0]    text_q;
  logic [ftp_tok_pkg::CLEN_W-1:0]    clen_q;
  logic [ftp_tok_pkg::PLEN_W-1:0]    plen_q;
  logic [7:0]                        pbyte_q;
  logic                              last_q;

  assign ch = (rx_byte_i == ftp_tok_pkg::CH_BSLASH) ? ftp_tok_pkg::CH_SLASH : rx_byte_i;

  // line geometry, valid at a line feed
  assign len    = zero_seen_q ? CW'(zero_pos_q) : fill_q;
  assign word   = sp_found_q ? CW'(sp_pos_q) : len;
  assign pstart = ps_found_q ? CW'(ps_pos_q) : len;
  assign plen   = sp_found_q ? (len - pstart) : '0;

  always_comb begin
    text = '0;
    for (int i = 0; i < NB; i++) begin
      if (CW'(i) < word) begin
        text[8*i +: 8] = word_q[i];
      end
    end
  end

  assign sts_o.is_cr      = (ch == ftp_tok_pkg::CH_CR);
  assign sts_o.is_lf      = (ch == ftp_tok_pkg::CH_LF);
  assign sts_o.full       = (fill_q == CW'(LineCapacity));
  assign sts_o.line_empty = (fill_q == '0);
  assign sts_o.word_bad   = (word > CW'(ftp_tok_pkg::CMD_MAX));
  assign sts_o.plen_zero  = (plen == '0);
  assign sts_o.param_last = (rem_q == CW'(1));

  // running scan of the line as it fills
  always_comb begin
    fill_d      = fill_q;
    zero_seen_d = zero_seen_q;
    zero_pos_d  = zero_pos_q;
    sp_found_d  = sp_found_q;
    sp_pos_d    = sp_pos_q;
    ps_found_d  = ps_found_q;
    ps_pos_d    = ps_pos_q;
    if (cmd_i.clear) begin
      fill_d      = '0;
      zero_seen_d = 1'b0;
      sp_found_d  = 1'b0;
      ps_found_d  = 1'b0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + CW'(1);
      if (!zero_seen_q) begin
        if (ch == ftp_tok_pkg::CH_NUL) begin
          zero_seen_d = 1'b1;
          zero_pos_d  = fill_q[AW-1:0];
        end else if (!sp_found_q && ch == ftp_tok_pkg::CH_SPACE) begin
          sp_found_d = 1'b1;
          sp_pos_d   = fill_q[AW-1:0];
        end else if (sp_found_q && !ps_found_q && ch != ftp_tok_pkg::CH_SPACE) begin
          ps_found_d = 1'b1;
          ps_pos_d   = fill_q[AW-1:0];
        end
      end
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    rem_d = rem_q;
    if (cmd_i.start_param) begin
      ptr_d = pstart[AW-1:0];
      rem_d = plen;
    end else if (cmd_i.advance) begin
      ptr_d = ptr_q + AW'(1);
      rem_d = rem_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      zero_seen_q <= 1'b0;
      zero_pos_q  <= '0;
      sp_found_q  <= 1'b0;
      sp_pos_q    <= '0;
      ps_found_q  <= 1'b0;
      ps_pos_q    <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
    end else begin
      fill_q      <= fill_d;
      zero_seen_q <= zero_seen_d;
      zero_pos_q  <= zero_pos_d;
      sp_found_q  <= sp_found_d;
      sp_pos_q    <= sp_pos_d;
      ps_found_q  <= ps_found_d;
      ps_pos_q    <= ps_pos_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
    end
  end

  // line buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[fill_q[AW-1:0]] <= ch;
    end
    rd_q <= mem_q[ptr_q];
  end

  // first characters of the line, uppercased
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && fill_q < CW'(NB)) begin
      word_q[fill_q[$clog2(NB)-1:0]] <= ftp_tok_pkg::upcase(ch);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= cmd_i.kind;
      text_q  <= '0;
      clen_q  <= '0;
      plen_q  <= '0;
      pbyte_q <= '0;
      last_q  <= 1'b1;
      unique case (cmd_i.kind)
        ftp_tok_pkg::KIND_CMD: begin
          text_q <= text;
          clen_q <= word[ftp_tok_pkg::CLEN_W-1:0];
          plen_q <= ftp_tok_pkg::PLEN_W'(plen);
          last_q <= (plen == '0);
        end
        ftp_tok_pkg::KIND_PARAM: begin
          pbyte_q <= rd_q;
          last_q  <= (rem_q == CW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  assign kind_o = kind_q;
  assign data_o = {7'd0, pbyte_q, plen_q, clen_q, text_q};
  assign last_o = last_q;

endmodule

>>> hdl/ftp_tok_ctrl.sv
// ----------------------------------------------------------------------------
// FTP tokenizer controller
// Sequences byte handling, the result burst at line end and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftp_tok_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ftp_tok_pkg::dp_sts_t   sts_i,
  output ftp_tok_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,  // buffer read in flight
    ST_EMIT  = 3'b100   // parameter byte ready for the output register
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_fire;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{store: 1'b0, clear: 1'b0, load: 1'b0, kind: ftp_tok_pkg::KIND_PENDING,
                start_param: 1'b0, advance: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          priority if (sts_i.is_cr) begin
            cmd_o.kind = ftp_tok_pkg::KIND_PENDING;
          end else if (!sts_i.is_lf) begin
            if (sts_i.full) begin
              cmd_o.clear = 1'b1;
              cmd_o.kind  = ftp_tok_pkg::KIND_TOO_LONG;
            end else begin
              cmd_o.store = 1'b1;
            end
          end else if (sts_i.line_empty) begin
            cmd_o.kind = ftp_tok_pkg::KIND_EMPTY;
          end else if (sts_i.word_bad) begin
            cmd_o.clear = 1'b1;
            cmd_o.kind  = ftp_tok_pkg::KIND_BAD_WORD;
          end else begin
            cmd_o.clear       = 1'b1;
            cmd_o.kind        = ftp_tok_pkg::KIND_CMD;
            cmd_o.start_param = 1'b1;
            if (!sts_i.plen_zero) begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.kind    = ftp_tok_pkg::KIND_PARAM;
          cmd_o.advance = 1'b1;
          state_d       = sts_i.param_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hdl/ftp_command_line_tokenizer.sv
// Control-channel command tokenizer. Bytes come in one per transfer on the
// slave stream; each byte yields one result on the master stream, except a
// line feed that closes a valid command, which yields the command result
// (uppercased word of up to four characters, its length and the count of
// parameter bytes) followed by one result per parameter byte, the final
// one flagged with tlast. Backslash is taken as slash, carriage return is
// dropped, and a zero byte ends the usable text of the line. An ordinary
// byte is taken whenever the output register is free or being drained. A
// command with parameter bytes holds the input until the last one is loaded;
// each needs a registered read of the line buffer, then an output register
// load that waits while the master side stalls. No clearing pass after
// reset; the line buffer is only read below its fill count.

// ----------------------------------------------------------------------------
// FTP command line tokenizer, top level
// Joins the controller and the datapath and maps the stream ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftp_command_line_tokenizer #(
  parameter int unsigned LineCapacity = 32  // line buffer depth, 5..63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] cmd_text, [34:32] cmd_len, [40:35] param_len,
  // [48:41] param_byte, [55:49] zero
  output logic [ftp_tok_pkg::TDATA_O_W-1:0] m_axis_tdata_o,
  output logic [ftp_tok_pkg::KIND_W-1:0]    m_axis_tuser_o,  // [2:0] kind
  output logic        m_axis_tlast_o    // last result caused by the input byte
);

  ftp_tok_pkg::ctrl_cmd_t cmd;
  ftp_tok_pkg::dp_sts_t   sts;

  // handshake sequencing and output valid
  ftp_tok_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // line buffer, line scan and result payload
  ftp_tok_dp #(
    .LineCapacity (LineCapacity)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (s_axis_tdata_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .kind_o    (m_axis_tuser_o),
    .data_o    (m_axis_tdata_o),
    .last_o    (m_axis_tlast_o)
  );

endmodule

>>> hdl/ftp_tok_checker.sv
// ----------------------------------------------------------------------------
// FTP tokenizer port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ftp_command_line_tokenizer_defines.svh"

module ftp_tok_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        is_cmd, is_param, is_burst;
  logic        in_fire, cr_in, cr_res, out_stall;
  logic [59:0] out_pay;
  logic [40:0] cmd_flds;
  logic [7:0]  pbyte;
  logic [2:0]  clen;

  assign is_cmd    = (m_axis_tuser_o == ftp_tok_pkg::KIND_CMD);
  assign is_param  = (m_axis_tuser_o == ftp_tok_pkg::KIND_PARAM);
  assign is_burst  = is_cmd || is_param;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign cr_in     = in_fire && (s_axis_tdata_i == ftp_tok_pkg::CH_CR);
  assign cr_res    = m_axis_tvalid_o && (m_axis_tuser_o == ftp_tok_pkg::KIND_PENDING) &&
                     m_axis_tlast_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_pay   = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign cmd_flds  = m_axis_tdata_o[40:0];
  assign pbyte     = m_axis_tdata_o[48:41];
  assign clen      = m_axis_tdata_o[34:32];

  // stalled result holds
  `FTP_TOK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_pay))

  // only command and parameter results can leave the burst open
  `FTP_TOK_ASSERT_IMPL(a_single_last, clk_i, rst_ni, m_axis_tvalid_o && !is_burst, m_axis_tlast_o)

  // command fields are zero outside a command result
  `FTP_TOK_ASSERT_IMPL(a_cmd_zero, clk_i, rst_ni, m_axis_tvalid_o && !is_cmd, cmd_flds == 41'd0)

  // parameter byte zero outside a parameter result; word length bounded
  `FTP_TOK_ASSERT_IMPL(a_param_zero, clk_i, rst_ni, m_axis_tvalid_o && !is_param, pbyte == 8'd0 && clen <= 3'd4)

  // a carriage return gives a single pending result on the next cycle
  `FTP_TOK_ASSERT_NEXT(a_cr_pending, clk_i, rst_ni, cr_in, cr_res)

endmodule

bind ftp_command_line_tokenizer ftp_tok_checker u_ftp_tok_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> bench/ftp_command_line_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// FTP command line tokenizer, testbench
// Drives control-channel bytes into the slave stream and compares every
// result transfer, field by field, against a line-level predictor kept in
// step with the accepted bytes. A short directed table comes first, then
// random lines: mostly well-formed commands with random content, plus bad
// command words, overflowing lines, empty lines and raw noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftp_command_line_tokenizer_tb;
  import ftp_tok_pkg::*;

  localparam int LINE_CAP     = 32;       // line buffer depth of the instance
  localparam int DIR_ROWS     = 21;
  localparam int RAND_ITEMS   = 450;
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 80;       // margin for the worst command burst
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 50;

  // One result transfer as the block should produce it.
  typedef struct {
    kind_e              kind;
    logic [TEXT_W-1:0]  text;
    logic [CLEN_W-1:0]  clen;
    logic [PLEN_W-1:0]  plen;
    logic [7:0]         pbyte;
    logic               last;
  } token_t;

  // Directed row: the byte, and a typed-in kind where the answer is obvious.
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    kind_e      kind;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_O_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  // Travel with s_axis_tdata so the monitor knows how to predict the byte.
  bit    row_typed = 1'b0;
  kind_e row_kind  = KIND_PENDING;

  // Predictor state: the line buffer and its fill level.
  logic [7:0] line_buf [LINE_CAP];
  int         line_fill = 0;
  token_t     token_q [$];          // results still owed by the block

  int  mismatches  = 0;
  int  tokens_seen = 0;
  int  bytes_sent  = 0;
  int  cycle_cnt   = 0;
  bit  hold_req    = 1'b0;          // sender asks the receiver for a hold-off
  bit  tail_phase  = 1'b0;          // no idling on either side

  dir_row_t dir_rows [DIR_ROWS];

  ftp_command_line_tokenizer #(
    .LineCapacity(LINE_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void add_token(kind_e k, logic [TEXT_W-1:0] txt, int clen, int plen,
                                    logic [7:0] pb, logic lst);
    token_t t;
    t.kind  = k;
    t.text  = txt;
    t.clen  = CLEN_W'(clen);
    t.plen  = PLEN_W'(plen);
    t.pbyte = pb;
    t.last  = lst;
    token_q.push_back(t);
  endfunction

  // Works out the results of one accepted byte and updates the line state.
  function automatic void tokenize_byte(input logic [7:0] rx);
    logic [7:0]        c;
    logic [7:0]        ch;
    logic [TEXT_W-1:0] word_txt;
    int                txt_len;
    int                sp;
    int                word_len;
    int                pstart;
    int                plen;
    bit                found;
    c = (rx == CH_BSLASH) ? CH_SLASH : rx;
    if (c == CH_CR) begin
      add_token(KIND_PENDING, '0, 0, 0, 8'h00, 1'b1);
    end else if (c != CH_LF) begin
      if (line_fill < LINE_CAP) begin
        line_buf[line_fill] = c;
        line_fill++;
        add_token(KIND_PENDING, '0, 0, 0, 8'h00, 1'b1);
      end else begin
        // overflow: byte dropped, line thrown away
        line_fill = 0;
        add_token(KIND_TOO_LONG, '0, 0, 0, 8'h00, 1'b1);
      end
    end else if (line_fill == 0) begin
      add_token(KIND_EMPTY, '0, 0, 0, 8'h00, 1'b1);
    end else begin
      // usable text stops at the first zero byte
      txt_len = 0;
      while (txt_len < line_fill && line_buf[txt_len] != CH_NUL) txt_len++;
      found = 1'b0;
      sp = 0;
      while (sp < txt_len && !found) begin
        if (line_buf[sp] == CH_SPACE) found = 1'b1;
        else sp++;
      end
      word_len = found ? sp : txt_len;
      line_fill = 0;
      if (word_len > CMD_MAX) begin
        add_token(KIND_BAD_WORD, '0, 0, 0, 8'h00, 1'b1);
      end else begin
        word_txt = '0;
        for (int i = 0; i < word_len; i++) begin
          ch = line_buf[i];
          if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'h20;
          word_txt[8*i +: 8] = ch;
        end
        plen = 0;
        pstart = txt_len;
        if (found) begin
          pstart = sp + 1;
          while (pstart < txt_len && line_buf[pstart] == CH_SPACE) pstart++;
          plen = txt_len - pstart;
        end
        add_token(KIND_CMD, word_txt, word_len, plen, 8'h00, plen == 0);
        for (int i = 0; i < plen; i++) begin
          add_token(KIND_PARAM, '0, 0, 0, line_buf[pstart + i], i + 1 == plen);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, tokens_seen, what,
               got, want);
    end
  endtask

  // Samples both streams with the values they held just before the edge.
  always @(posedge clk_i) begin : monitor
    token_t want;
    int     owed;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed = token_q.size();
        tokenize_byte(s_axis_tdata);
        // typed rows: keep the predictor state, but check against the table
        if (row_typed) begin
          while (token_q.size() > owed) void'(token_q.pop_back());
          add_token(row_kind, '0, 0, 0, 8'h00, 1'b1);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_q.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(m_axis_tuser), 32'h0);
        end else begin
          want = token_q.pop_front();
          // tdata fields, low bit up: cmd_text, cmd_len, param_len, param_byte
          if (m_axis_tuser !== want.kind)
            report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata[31:0] !== want.text)
            report_mismatch("cmd_text", m_axis_tdata[31:0], want.text);
          if (m_axis_tdata[34:32] !== want.clen)
            report_mismatch("cmd_len", 32'(m_axis_tdata[34:32]), 32'(want.clen));
          if (m_axis_tdata[40:35] !== want.plen)
            report_mismatch("param_len", 32'(m_axis_tdata[40:35]), 32'(want.plen));
          if (m_axis_tdata[48:41] !== want.pbyte)
            report_mismatch("param_byte", 32'(m_axis_tdata[48:41]), 32'(want.pbyte));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        end
        tokens_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it was accepted. A random
  // gap may come first; tvalid stays high between back-to-back transfers.
  task automatic send_byte(input logic [7:0] rx, input bit typed, input kind_e k);
    if (!tail_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    row_typed     <= typed;
    row_kind      <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(8'h41, 8'h5A));
    if ($urandom_range(0, 1) == 1) c = c + 8'h20;
    return c;
  endfunction

  // Any byte that neither ends the line nor is dropped.
  function automatic logic [7:0] rand_line_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_LF || c == CH_CR) c = 8'h7F;
    return c;
  endfunction

  function automatic logic [7:0] rand_param_char();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1:    c = CH_BSLASH;
      2, 3:    c = CH_SPACE;
      4, 5:    c = rand_line_byte();
      6:       c = CH_NUL;
      default: c = 8'($urandom_range(8'h21, 8'h7E));
    endcase
    return c;
  endfunction

  // Builds one line of a random category and sends it.
  task automatic send_random_line();
    logic [7:0] line_q [$];
    int         pick;
    int         wlen;
    int         nsp;
    int         room;
    int         plen;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // well-formed command: word, spaces, parameter text
      wlen = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, CMD_MAX);
      repeat (wlen) line_q.push_back(rand_letter());
      if ($urandom_range(0, 4) != 0) begin
        nsp = $urandom_range(1, 3);
        repeat (nsp) line_q.push_back(CH_SPACE);
        room = LINE_CAP - wlen - nsp;
        plen = ($urandom_range(0, 7) == 0) ? room : $urandom_range(0, room < 12 ? room : 12);
        repeat (plen) line_q.push_back(rand_param_char());
      end
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end else if (pick < 70) begin
      // command word too long, with or without a space after it
      repeat ($urandom_range(CMD_MAX + 1, 12)) line_q.push_back(rand_letter());
      if ($urandom_range(0, 1) == 1) begin
        line_q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 6)) line_q.push_back(rand_param_char());
      end
      line_q.push_back(CH_LF);
    end else if (pick < 78) begin
      // overflow; the tail after the overflow starts a fresh line
      repeat ($urandom_range(LINE_CAP + 1, LINE_CAP + 8)) line_q.push_back(rand_line_byte());
      line_q.push_back(CH_LF);
    end else if (pick < 86) begin
      if ($urandom_range(0, 1) == 1) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end else begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) line_q.push_back(CH_LF);
    end
    foreach (line_q[i]) send_byte(line_q[i], 1'b0, KIND_PENDING);
  endtask

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // Directed table. Typed rows: empty line right after reset, a carriage
    // return, the byte extremes, and a five-letter word with no space.
    dir_dows_init: begin
      dir_rows = '{
        '{CH_LF,  1'b1, KIND_EMPTY},
        '{CH_CR,  1'b1, KIND_PENDING},
        '{"u",    1'b0, KIND_PENDING},     // "uSer  a\<FF>": mixed case word,
        '{"S",    1'b0, KIND_PENDING},     // extra spaces skipped, backslash
        '{"e",    1'b0, KIND_PENDING},     // turned into slash, top byte value
        '{"r",    1'b0, KIND_PENDING},
        '{CH_SPACE, 1'b0, KIND_PENDING},
        '{CH_SPACE, 1'b0, KIND_PENDING},
        '{"a",    1'b0, KIND_PENDING},
        '{CH_BSLASH, 1'b0, KIND_PENDING},
        '{8'hFF,  1'b1, KIND_PENDING},
        '{CH_LF,  1'b0, KIND_PENDING},
        '{CH_NUL, 1'b1, KIND_PENDING},     // leading zero: not empty, zero-length word
        '{"x",    1'b0, KIND_PENDING},
        '{CH_LF,  1'b0, KIND_PENDING},
        '{"a",    1'b0, KIND_PENDING},
        '{"b",    1'b0, KIND_PENDING},
        '{"c",    1'b0, KIND_PENDING},
        '{"d",    1'b0, KIND_PENDING},
        '{"e",    1'b0, KIND_PENDING},
        '{CH_LF,  1'b1, KIND_BAD_WORD}
      };
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].kind);

    while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
      // long receiver hold-off while bytes keep coming: the block backs up
      if (!hold_done && bytes_sent >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // sender pause until the block has delivered everything it owes
      if (!pause_done && bytes_sent >= 300) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (token_q.size() != 0);
        pause_done = 1'b1;
      end
      if (bytes_sent >= 390) tail_phase = 1'b1;
      send_random_line();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (token_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (token_q.size() != 0) report_mismatch("results still owed", token_q.size(), 32'h0);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
